// ----- rtl/core/nrmc_pkg.sv -----
// Package for the NMEA RMC time parser: character codes, time constants,
// the result type and the month offset table. No dependencies.
`default_nettype none

package nrmc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] HEX_GAP   = 8'd7;

  localparam logic [31:0] SECS_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_MINUTE = 32'd60;
  localparam logic [31:0] SECS_DAY    = 32'd86400;
  localparam logic [31:0] SECS_YEAR   = 32'd31536000;
  localparam logic [31:0] SECS_EPOCH  = 32'd946684800;

  typedef struct packed {
    logic [31:0] unix_time;
    logic        time_valid;
  } nrmc_result_t;

  // Seconds in the whole months before the given month (1 to 12).
  function automatic logic [31:0] month_secs(input logic [3:0] month);
    logic [31:0] secs;
    unique case (month)
      4'd1:    secs = 32'd0;
      4'd2:    secs = 32'd2678400;
      4'd3:    secs = 32'd5097600;
      4'd4:    secs = 32'd7776000;
      4'd5:    secs = 32'd10368000;
      4'd6:    secs = 32'd13046400;
      4'd7:    secs = 32'd15638400;
      4'd8:    secs = 32'd18316800;
      4'd9:    secs = 32'd20995200;
      4'd10:   secs = 32'd23587200;
      4'd11:   secs = 32'd26265600;
      4'd12:   secs = 32'd28857600;
      default: secs = 32'd0;
    endcase
    return secs;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nrmc_in_reg.sv -----
// Input register of the NMEA RMC time parser: holds one received byte until
// the parser core takes it. Depends on nothing.
`default_nettype none

module nrmc_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       pop,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || pop;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nrmc_core.sv -----
// Parser core of the NMEA RMC time parser: sentence state, checksum, digit
// accumulation and the result at carriage return. Depends on nrmc_pkg.
`default_nettype none

module nrmc_core
  import nrmc_pkg::*;
#(
  parameter int BUFFER_BYTES = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  input  wire logic       out_space,
  output logic            pop,
  output logic            res_push,
  output nrmc_result_t    res
);

  localparam int POS_W = $clog2(BUFFER_BYTES);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES - 2);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             header_r, header_nxt;
  logic [3:0]       field_r, field_nxt;
  logic [2:0]       tcnt_r, tcnt_nxt;
  logic [2:0]       dcnt_r, dcnt_nxt;
  logic [6:0]       tens_r, tens_nxt;
  logic [3:0]       month_r, month_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic [7:0]       exp_r, exp_nxt;
  logic             star_r, star_nxt;
  logic             bad_r, bad_nxt;

  logic        digit_ok;
  logic [3:0]  dval;
  logic [6:0]  v;
  logic [7:0]  hex_d;
  logic [5:0]  quarter;
  logic [31:0] day_adj;
  logic        sent_ok;

  always_comb begin
    pos_nxt    = pos_r;
    header_nxt = header_r;
    field_nxt  = field_r;
    tcnt_nxt   = tcnt_r;
    dcnt_nxt   = dcnt_r;
    tens_nxt   = tens_r;
    month_nxt  = month_r;
    sum_nxt    = sum_r;
    chk_nxt    = chk_r;
    exp_nxt    = exp_r;
    star_nxt   = star_r;
    bad_nxt    = bad_r;
    res_push   = 1'b0;

    digit_ok = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
    dval     = digit_ok ? byte_data[3:0] : 4'd0;
    v        = tens_r + 7'(dval);
    hex_d    = byte_data - CH_ZERO;
    if (byte_data > CH_NINE) begin
      hex_d = hex_d - HEX_GAP;
    end
    quarter  = 6'((8'(v) + 8'd3) >> 2);
    day_adj  = 32'(quarter) + 32'((month_r > 4'd2) && (v[1:0] == 2'b00));

    sent_ok = header_r && (pos_r >= POS_W'(6)) && star_r && (chk_r == exp_r) &&
              !bad_r && (tcnt_r == 3'd6) && (dcnt_r == 3'd6) && (sum_r != 32'd0);
    res.time_valid = sent_ok;
    res.unix_time  = sent_ok ? (sum_r + SECS_EPOCH) : 32'd0;

    if (byte_data == CH_LF) begin
      // Line feeds leave the state alone.
    end else if (byte_data == CH_CR) begin
      res_push   = 1'b1;
      pos_nxt    = '0;
      header_nxt = 1'b0;
      field_nxt  = 4'd0;
      tcnt_nxt   = 3'd0;
      dcnt_nxt   = 3'd0;
      tens_nxt   = 7'd0;
      month_nxt  = 4'd0;
      sum_nxt    = 32'd0;
      chk_nxt    = 8'd0;
      exp_nxt    = 8'd0;
      star_nxt   = 1'b0;
      bad_nxt    = 1'b0;
    end else if (pos_r >= POS_LIMIT) begin
      // The buffer is full, so the byte is dropped.
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r == '0) begin
        header_nxt = (byte_data == CH_DOLLAR);
      end else begin
        if ((pos_r == POS_W'(5)) && (byte_data != CH_C)) begin
          header_nxt = 1'b0;
        end
        if (byte_data == CH_COMMA) begin
          chk_nxt = chk_r ^ byte_data;
          if (field_r != 4'd15) begin
            field_nxt = field_r + 4'd1;
          end
        end else if (byte_data == CH_STAR) begin
          star_nxt = 1'b1;
        end else if (!star_r) begin
          chk_nxt = chk_r ^ byte_data;
          if ((field_r == 4'd1) && (tcnt_r < 3'd6)) begin
            bad_nxt  = bad_r || !digit_ok;
            tcnt_nxt = tcnt_r + 3'd1;
            if (!tcnt_r[0]) begin
              tens_nxt = 7'(dval) * 7'd10;
            end else begin
              tens_nxt = 7'd0;
              unique case (tcnt_r)
                3'd1:    sum_nxt = sum_r + 32'(v) * SECS_HOUR;
                3'd3:    sum_nxt = sum_r + 32'(v) * SECS_MINUTE;
                default: sum_nxt = sum_r + 32'(v);
              endcase
            end
          end else if ((field_r == 4'd9) && (dcnt_r < 3'd6)) begin
            bad_nxt  = bad_r || !digit_ok;
            dcnt_nxt = dcnt_r + 3'd1;
            if (!dcnt_r[0]) begin
              tens_nxt = 7'(dval) * 7'd10;
            end else begin
              tens_nxt = 7'd0;
              unique case (dcnt_r)
                3'd1: begin
                  sum_nxt = sum_r + 32'(v) * SECS_DAY;
                end
                3'd3: begin
                  if ((v >= 7'd1) && (v <= 7'd12)) begin
                    month_nxt = v[3:0];
                    sum_nxt   = sum_r + month_secs(v[3:0]);
                  end else begin
                    month_nxt = 4'd0;
                    bad_nxt   = 1'b1;
                  end
                end
                default: begin
                  // Whole years and leap days (of earlier years, and of this year past
                  // February), less one day because the day of month counts from one.
                  sum_nxt = sum_r + 32'(v) * SECS_YEAR + day_adj * SECS_DAY - SECS_DAY;
                end
              endcase
            end
          end
        end else begin
          exp_nxt = {exp_r[3:0], 4'd0} + hex_d;
        end
      end
    end

    pop = byte_valid && ((byte_data != CH_CR) || out_space);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      header_r <= 1'b0;
      field_r  <= 4'd0;
      tcnt_r   <= 3'd0;
      dcnt_r   <= 3'd0;
      tens_r   <= 7'd0;
      month_r  <= 4'd0;
      sum_r    <= 32'd0;
      chk_r    <= 8'd0;
      exp_r    <= 8'd0;
      star_r   <= 1'b0;
      bad_r    <= 1'b0;
    end else if (pop) begin
      pos_r    <= pos_nxt;
      header_r <= header_nxt;
      field_r  <= field_nxt;
      tcnt_r   <= tcnt_nxt;
      dcnt_r   <= dcnt_nxt;
      tens_r   <= tens_nxt;
      month_r  <= month_nxt;
      sum_r    <= sum_nxt;
      chk_r    <= chk_nxt;
      exp_r    <= exp_nxt;
      star_r   <= star_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nrmc_out_reg.sv -----
// Result register of the NMEA RMC time parser: holds one result until the
// consumer takes it. Depends on nrmc_pkg.
`default_nettype none

module nrmc_out_reg
  import nrmc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire nrmc_result_t  res,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output nrmc_result_t       out_res
);

  logic         valid_r;
  nrmc_result_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (space && push) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/nmea_rmc_time_parser_top.sv -----
// Top level of the NMEA RMC time parser: input register, parser core and
// result register. Depends on nrmc_pkg, nrmc_in_reg, nrmc_core, nrmc_out_reg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_rx_byte[7:0]
//   out      output     out_valid / out_ready out_unix_time[31:0], out_time_valid
//
// One byte is accepted per cycle while nothing stalls; a byte waits in the
// input register and reaches the parser state when the core pops it, and a
// carriage return puts its result on the output register at that same edge,
// raising out_valid. Only a carriage return can stall, when the result
// register still holds an untaken result; other bytes keep flowing. Reset
// (rst_n low, synchronous) empties both registers and clears the sentence state.
`default_nettype none

module nmea_rmc_time_parser_top
  import nrmc_pkg::*;
#(
  parameter int BUFFER_BYTES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_unix_time,
  output logic             out_time_valid
);

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         pop;
  logic         res_push;
  logic         out_space;
  nrmc_result_t res;
  nrmc_result_t out_res;

  nrmc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  nrmc_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .out_space  (out_space),
    .pop        (pop),
    .res_push   (res_push),
    .res        (res)
  );

  nrmc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pop && res_push),
    .res       (res),
    .space     (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_unix_time  = out_res.unix_time;
  assign out_time_valid = out_res.time_valid;

  // A carriage return is only taken from the input register when the result
  // register can hold its result.
  a_cr_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && byte_data == CH_CR) |-> out_space)
    else $error("carriage return taken without room for its result");

  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && !pop) |=> (byte_valid && $stable(byte_data)))
    else $error("pending byte lost or changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_time_valid) |-> (out_unix_time == 32'd0))
    else $error("invalid result carries a nonzero time");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_time_valid) |-> (out_unix_time != SECS_EPOCH))
    else $error("valid result with zero time since 2000");

endmodule

`default_nettype wire
